// ===== design/tsp_pkg.sv =====
// Package for the trapezoidal speed profile block: sequencer states,
// the control bundle decoded from the state, and arithmetic widths.
// No dependencies.
package tsp_pkg;

  localparam int unsigned POS_W   = 32;  // position and velocity words
  localparam int unsigned LIM_W   = 20;  // configured limits
  localparam int unsigned DIST_W  = 33;  // remaining distance, no wrap
  localparam int unsigned PROD_W  = 52;  // shared multiplier product
  localparam int unsigned RAD_W   = 54;  // square root radicand
  localparam int unsigned ROOT_W  = 55;  // root accumulator and trial term
  localparam int unsigned ARITH_W = 34;  // signed working width for limits
  localparam int unsigned ROOT_STEPS = 27;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned IDX_W   = 2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_SPEED = 2'd0;
  localparam logic [IDX_W-1:0] REG_ACCEL = 2'd1;
  localparam logic [IDX_W-1:0] REG_DECEL = 2'd2;

  // item kinds
  localparam logic KIND_STEP = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_MUL_DS,
    ST_MUL_SQ,
    ST_SUM,
    ST_ROOT,
    ST_LIMIT,
    ST_WRITE
  } tsp_state_e;

  // control decoded from the sequencer state
  typedef struct packed {
    logic in_stall;
    logic mul_square;
    logic do_write;
  } tsp_ctrl_t;

endpackage

// ===== design/trapezoidal_speed_profile.sv =====
// Trapezoidal speed profile generator: top level with the sequencer and
// its shared multiplier and square root step unit. Depends on tsp_pkg.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o   | kind, target_position, load_velocity
//  out     | output    | out_valid_o / out_stall_i | position, velocity
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A step item runs through distance, two passes through one 32x20
// multiplier, a sum, 27 square root steps (one bit of root per cycle on a
// 55-bit compare and subtract), a limit step and the write. A load item
// goes from its transfer straight to the write. One item is in work at a
// time; the next transfer is taken in the idle state after the write, so
// the block takes no new item before it is through with the last one.
// Reset clears the limits, position and velocity. A stalled result holds
// the state and the sequencer waits in its write cycle.
module trapezoidal_speed_profile (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                kind_i,
  input  logic signed [tsp_pkg::POS_W-1:0]    target_position_i,
  input  logic signed [tsp_pkg::POS_W-1:0]    load_velocity_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [tsp_pkg::POS_W-1:0]    position_o,
  output logic signed [tsp_pkg::POS_W-1:0]    velocity_o,
  // configuration channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic        [tsp_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic        [tsp_pkg::LIM_W-1:0]    cfg_data_i
);

  localparam int unsigned POS_W   = tsp_pkg::POS_W;
  localparam int unsigned LIM_W   = tsp_pkg::LIM_W;
  localparam int unsigned DIST_W  = tsp_pkg::DIST_W;
  localparam int unsigned PROD_W  = tsp_pkg::PROD_W;
  localparam int unsigned RAD_W   = tsp_pkg::RAD_W;
  localparam int unsigned ROOT_W  = tsp_pkg::ROOT_W;
  localparam int unsigned ARITH_W = tsp_pkg::ARITH_W;
  localparam int unsigned CNT_W   = tsp_pkg::CNT_W;

  tsp_pkg::tsp_state_e state_q, state_d;
  tsp_pkg::tsp_ctrl_t  ctrl;

  logic [LIM_W-1:0] speed_q, accel_q, decel_q;
  logic signed [POS_W-1:0] pos_q, vel_q;
  logic out_valid_q;
  logic out_free;

  // latched item
  logic                    kind_q;
  logic signed [POS_W-1:0] target_q, lvel_q;

  // datapath registers
  logic signed [DIST_W-1:0] ds_q;
  logic [DIST_W-1:0]        dist_q;
  logic [POS_W-1:0]         mag_q;
  logic [PROD_W-1:0]        prod_ds_q, prod_sq_q;
  logic [RAD_W-1:0]         rem_q;
  logic [ROOT_W-1:0]        res_q, bit_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [POS_W-1:0]         vmax_q;

  logic              in_xfer;
  logic [LIM_W-2:0]  half;
  logic [POS_W-1:0]  mul_a;
  logic [LIM_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_xfer     = in_valid_i && !ctrl.in_stall;
  assign half        = decel_q[LIM_W-1:1];
  assign in_stall_o  = ctrl.in_stall;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign position_o  = pos_q;
  assign velocity_o  = vel_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tsp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (kind_i == tsp_pkg::KIND_LOAD) ? tsp_pkg::ST_WRITE : tsp_pkg::ST_DIST;
        end
      end
      tsp_pkg::ST_DIST:   state_d = tsp_pkg::ST_MUL_DS;
      tsp_pkg::ST_MUL_DS: state_d = tsp_pkg::ST_MUL_SQ;
      tsp_pkg::ST_MUL_SQ: state_d = tsp_pkg::ST_SUM;
      tsp_pkg::ST_SUM:    state_d = tsp_pkg::ST_ROOT;
      tsp_pkg::ST_ROOT: begin
        if (cnt_q == '0) begin
          state_d = tsp_pkg::ST_LIMIT;
        end
      end
      tsp_pkg::ST_LIMIT:  state_d = tsp_pkg::ST_WRITE;
      tsp_pkg::ST_WRITE: begin
        if (out_free) begin
          state_d = tsp_pkg::ST_IDLE;
        end
      end
      default: state_d = tsp_pkg::ST_IDLE;
    endcase
  end

  // control outputs of the sequencer
  always_comb begin
    ctrl            = '0;
    ctrl.in_stall   = (state_q != tsp_pkg::ST_IDLE);
    ctrl.mul_square = (state_q == tsp_pkg::ST_MUL_SQ);
    ctrl.do_write   = (state_q == tsp_pkg::ST_WRITE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= '0;
      accel_q <= '0;
      decel_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == tsp_pkg::REG_SPEED) speed_q <= cfg_data_i;
      if (cfg_index_i == tsp_pkg::REG_ACCEL) accel_q <= cfg_data_i;
      if (cfg_index_i == tsp_pkg::REG_DECEL) decel_q <= cfg_data_i;
    end
  end

  // shared multiplier: distance by deceleration, then half by half
  always_comb begin
    if (ctrl.mul_square) begin
      mul_a = {{(POS_W-LIM_W+1){1'b0}}, half};
      mul_b = {1'b0, half};
    end else begin
      mul_a = dist_q[POS_W-1:0];
      mul_b = decel_q;
    end
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // square root step, stop speed and final limit
  logic [ROOT_W-1:0]         trial;
  logic [RAD_W-1:0]          rad;
  logic [PROD_W:0]           ds_term;
  logic signed [ARITH_W-1:0] stop, vcap, amag, cand, vlim;

  always_comb begin
    trial   = res_q + bit_q;
    ds_term = {1'b0, prod_ds_q}
            + (dist_q[DIST_W-1] ? ((PROD_W+1)'(decel_q) << POS_W) : '0);
    rad     = {ds_term, 1'b0} + RAD_W'(prod_sq_q);

    stop = $signed(ARITH_W'(res_q[ARITH_W-3:0])) - $signed(ARITH_W'(half));
    vcap = ($signed(ARITH_W'(speed_q)) < stop) ? $signed(ARITH_W'(speed_q)) : stop;
    amag = $signed(ARITH_W'(mag_q));
    if (amag < vcap) begin
      cand = amag + $signed(ARITH_W'(accel_q));
      vlim = (vcap > cand) ? cand : vcap;
    end else begin
      cand = amag - $signed(ARITH_W'(decel_q));
      vlim = (cand > vcap) ? cand : vcap;
    end
  end

  // datapath registers, advanced by the sequencer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q   <= kind_i;
      target_q <= target_position_i;
      lvel_q   <= load_velocity_i;
    end
    unique case (state_q)
      tsp_pkg::ST_DIST: begin
        ds_q   <= DIST_W'(target_q) - DIST_W'(pos_q);
        dist_q <= (DIST_W'(target_q) - DIST_W'(pos_q) < 0)
                ? DIST_W'(pos_q) - DIST_W'(target_q)
                : DIST_W'(target_q) - DIST_W'(pos_q);
        mag_q  <= vel_q[POS_W-1] ? POS_W'(-vel_q) : POS_W'(vel_q);
      end
      tsp_pkg::ST_MUL_DS: prod_ds_q <= mul_p;
      tsp_pkg::ST_MUL_SQ: prod_sq_q <= mul_p;
      tsp_pkg::ST_SUM: begin
        rem_q <= rad;
        res_q <= '0;
        bit_q <= ROOT_W'(1) << (2 * (tsp_pkg::ROOT_STEPS - 1));
        cnt_q <= CNT_W'(tsp_pkg::ROOT_STEPS - 1);
      end
      tsp_pkg::ST_ROOT: begin
        if (ROOT_W'(rem_q) >= trial) begin
          rem_q <= rem_q - trial[RAD_W-1:0];
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        cnt_q <= cnt_q - 1'b1;
      end
      tsp_pkg::ST_LIMIT: vmax_q <= vlim[POS_W-1:0];
      default: ;
    endcase
  end

  // position and velocity update at the write cycle
  logic signed [ARITH_W-1:0] dsx, vmx, vel_new;
  logic signed [POS_W-1:0]   pos_new, vel_out;

  always_comb begin
    dsx = ARITH_W'(ds_q);
    vmx = $signed(ARITH_W'(vmax_q));
    if (dsx > vmx) begin
      pos_new = pos_q + $signed(vmax_q);
      vel_new = vmx;
    end else if (dsx < -vmx) begin
      pos_new = pos_q - $signed(vmax_q);
      vel_new = -vmx;
    end else begin
      pos_new = target_q;
      vel_new = dsx;
    end
    // saturate a velocity above two to the 31 minus one
    if (vel_new > $signed(ARITH_W'({1'b0, {(POS_W-1){1'b1}}}))) begin
      vel_out = {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      vel_out = vel_new[POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      vel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl.do_write) begin
        out_valid_q <= 1'b1;
        if (kind_q == tsp_pkg::KIND_LOAD) begin
          pos_q <= target_q;
          vel_q <= lvel_q;
        end else begin
          pos_q <= pos_new;
          vel_q <= vel_out;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
